// ===== sv/hbia_pkg.sv =====
// ============================================================================
// Hierarchical bitmap ID allocator package
// Shared constants and the request operation codes.
// ============================================================================
`default_nettype none

package hbia_pkg;

    // Default sizing of the allocator.
    localparam int ID_BITS_DEF     = 16;
    localparam int WORD_BITS_DEF   = 64;
    localparam int GROUP_WORDS_DEF = 16;

    // Fixed widths of the request and result fields.
    localparam int MODE_W  = 2;
    localparam int IDENT_W = 16;

    // Request operations.
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT   = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_ALLOC    = 2'd3
    } t_mode;

endpackage : hbia_pkg

`default_nettype wire

// ===== sv/hierarchical_bitmap_id_allocator.sv =====
// ============================================================================
// Hierarchical bitmap ID allocator
// Bitmap of used IDs with two summary levels of free marks, serving insert,
// remove, contains and allocate-lowest-free requests.
// ============================================================================
// An out-of-range ID or a full set goes straight to the final state; an
// allocate reads the mark memory, then the bitmap memory, and on success writes
// back; insert, remove and contains run two passes of the divide-by-word-width
// sequence and one memory read, and a successful insert or remove writes back.
// Requests are taken one at a time: the next request is taken when the
// sequencer is back in idle, which the read-modify-write of the two memories
// and a stalled result channel hold off. After reset a clearing pass sweeps
// the bitmap memory (and the mark memory in its first entries) with no request accepted.
`default_nettype none

module hierarchical_bitmap_id_allocator #(
    parameter int ID_BITS     = hbia_pkg::ID_BITS_DEF,
    parameter int WORD_BITS   = hbia_pkg::WORD_BITS_DEF,
    parameter int GROUP_WORDS = hbia_pkg::GROUP_WORDS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Request channel.
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire  [hbia_pkg::MODE_W-1:0]       i_mode,
    input  wire  [hbia_pkg::IDENT_W-1:0]      i_ident,
    // Result channel.
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic                              o_ok,
    output logic [hbia_pkg::IDENT_W-1:0]      o_ident_out
);

    // ------------------------------------------------------------------------
    // Sizing. Each mark word covers WORD_BITS bitmap words, and there are
    // GROUP_WORDS mark words, so the bitmap has GROUP_WORDS*WORD_BITS words.
    // ------------------------------------------------------------------------
    localparam int IW        = hbia_pkg::IDENT_W;
    localparam int NUM_WORDS = GROUP_WORDS * WORD_BITS;
    localparam int NUM_IDS   = NUM_WORDS * WORD_BITS;
    localparam int WAW       = $clog2(NUM_WORDS);
    localparam int EW        = $clog2(GROUP_WORDS);
    localparam int BW        = $clog2(WORD_BITS);

    // The incoming ident is reduced to its low ID_BITS bits.
    localparam logic [IW-1:0] ID_MASK =
        (ID_BITS >= IW) ? {IW{1'b1}} : IW'((1 << ID_BITS) - 1);

    // Division by WORD_BITS is a multiplication by a truncated reciprocal.
    // The quotient estimate is at most one short for any 16-bit dividend,
    // so one compare-and-subtract step finishes it.
    localparam int DIV_M = (1 << IW) / WORD_BITS;
    localparam int MW    = $clog2(DIV_M + 1);

    // ------------------------------------------------------------------------
    // Sequencer states, one-hot.
    // ------------------------------------------------------------------------
    typedef enum logic [13:0] {
        ST_CLEAR      = 14'b00000000000001,
        ST_IDLE       = 14'b00000000000010,
        ST_DIV_MUL    = 14'b00000000000100,
        ST_DIV_BACK   = 14'b00000000001000,
        ST_DIV_FIX    = 14'b00000000010000,
        ST_RD_USED    = 14'b00000000100000,
        ST_MODIFY     = 14'b00000001000000,
        ST_A_RD_MARKS = 14'b00000010000000,
        ST_A_MARKS    = 14'b00000100000000,
        ST_A_WORD     = 14'b00001000000000,
        ST_A_RD_USED  = 14'b00010000000000,
        ST_A_USED     = 14'b00100000000000,
        ST_UPDATE     = 14'b01000000000000,
        ST_DONE       = 14'b10000000000000
    } t_state;

    // Index of the lowest set bit of a bitmap or mark word.
    function automatic logic [BW-1:0] low_bit(input logic [WORD_BITS-1:0] v);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BW'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest set bit of the group marks.
    function automatic logic [EW-1:0] low_entry(input logic [GROUP_WORDS-1:0] v);
        logic [EW-1:0] idx;
        idx = '0;
        for (int i = GROUP_WORDS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = EW'(i);
            end
        end
        return idx;
    endfunction

    // ------------------------------------------------------------------------
    // Storage. The bitmap and the first summary level live in synchronous
    // memories with one write and one read port; the top summary level is a plain register.
    // ------------------------------------------------------------------------
    logic [WORD_BITS-1:0]   used_mem  [NUM_WORDS];
    logic [WORD_BITS-1:0]   marks_mem [GROUP_WORDS];
    logic [WORD_BITS-1:0]   r_used_rd;
    logic [WORD_BITS-1:0]   r_marks_rd;
    logic [GROUP_WORDS-1:0] r_group;

    t_state                 r_state;
    logic [WAW-1:0]         r_clr_addr;

    // Request context.
    hbia_pkg::t_mode        r_mode;
    logic                   r_inrange;
    logic [WAW-1:0]         r_word;
    logic [BW-1:0]          r_bit;
    logic [EW-1:0]          r_entry;
    logic [BW-1:0]          r_mbit;
    logic [WORD_BITS-1:0]   r_marks;
    logic [WORD_BITS-1:0]   r_newword;
    logic                   r_ok;
    logic [IW-1:0]          r_res_id;

    // Divide-by-word-width sequence.
    logic [IW-1:0]          r_div_in;
    logic                   r_div_pass;
    logic [MW-1:0]          r_prod;
    logic [MW-1:0]          r_q;
    logic [IW-1:0]          r_qw;

    // Output register.
    logic                   r_o_valid;
    logic                   r_o_ok;
    logic [IW-1:0]          r_o_ident;

    // ------------------------------------------------------------------------
    // Combinational helpers.
    // ------------------------------------------------------------------------
    logic [IW-1:0]          in_id;
    logic [MW-1:0]          div_q0;
    logic [IW-1:0]          div_rem;
    logic                   div_over;
    logic [MW-1:0]          div_q;
    logic [IW-1:0]          div_r;
    logic [WORD_BITS-1:0]   bit_mask;
    logic                   present;
    logic [WORD_BITS-1:0]   free_bits;
    logic [BW-1:0]          free_bit;
    logic [WORD_BITS-1:0]   mbit_mask;
    logic [WORD_BITS-1:0]   new_marks;
    logic                   out_free;

    logic                   used_we;
    logic [WAW-1:0]         used_waddr;
    logic [WORD_BITS-1:0]   used_wdata;
    logic                   marks_we;
    logic [EW-1:0]          marks_waddr;
    logic [WORD_BITS-1:0]   marks_wdata;

    always_comb begin
        in_id    = i_ident & ID_MASK;

        div_q0   = r_prod;
        div_rem  = r_div_in - r_qw;
        div_over = (div_rem >= IW'(WORD_BITS));
        div_q    = div_over ? (r_q + 1'b1) : r_q;
        div_r    = div_over ? (div_rem - IW'(WORD_BITS)) : div_rem;

        bit_mask  = WORD_BITS'(1) << r_bit;
        present   = |(r_used_rd & bit_mask);
        free_bits = ~r_used_rd;
        free_bit  = low_bit(free_bits);

        // A word with no free bit loses its mark; any other word has one.
        mbit_mask = WORD_BITS'(1) << r_mbit;
        if (&r_newword) begin
            new_marks = r_marks & ~mbit_mask;
        end else begin
            new_marks = r_marks | mbit_mask;
        end

        out_free = !r_o_valid || !i_stall;
    end

    // Memory write port: zeroes during the clearing pass, else write-back.
    always_comb begin
        used_we     = 1'b0;
        used_waddr  = r_word;
        used_wdata  = r_newword;
        marks_we    = 1'b0;
        marks_waddr = r_entry;
        marks_wdata = new_marks;
        if (r_state == ST_CLEAR) begin
            used_we     = 1'b1;
            used_waddr  = r_clr_addr;
            used_wdata  = '0;
            marks_we    = (32'(r_clr_addr) < GROUP_WORDS);
            marks_waddr = r_clr_addr[EW-1:0];
            marks_wdata = '1;
        end else if (r_state == ST_UPDATE) begin
            used_we  = 1'b1;
            marks_we = 1'b1;
        end
    end

    // Read addresses are held steady in the context registers, so a read
    // issued in one state has its data in the next.
    always_ff @(posedge i_clk) begin
        if (used_we) begin
            used_mem[used_waddr] <= used_wdata;
        end
        r_used_rd <= used_mem[r_word];
    end

    always_ff @(posedge i_clk) begin
        if (marks_we) begin
            marks_mem[marks_waddr] <= marks_wdata;
        end
        r_marks_rd <= marks_mem[r_entry];
    end

    // ------------------------------------------------------------------------
    // Sequencer. Requests run one at a time, so every write-back lands
    // before the next request reads; no forwarding path is needed.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_group    <= '1;
            r_o_valid  <= 1'b0;
            r_div_pass <= 1'b0;
        end else begin
            // The final state reloads the output register itself.
            if (r_o_valid && !i_stall && r_state != ST_DONE) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == WAW'(NUM_WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (i_valid) begin
                        r_mode     <= hbia_pkg::t_mode'(i_mode);
                        // An allocate reports a zero ID unless it succeeds.
                        r_res_id   <= (hbia_pkg::t_mode'(i_mode) == hbia_pkg::MODE_ALLOC) ?
                                      '0 : i_ident;
                        r_ok       <= 1'b0;
                        r_inrange  <= (32'(in_id) < NUM_IDS);
                        r_div_in   <= in_id;
                        r_div_pass <= 1'b0;
                        if (hbia_pkg::t_mode'(i_mode) == hbia_pkg::MODE_ALLOC) begin
                            r_entry <= low_entry(r_group);
                            if (r_group == '0) begin
                                // Set full: fail with a zero ID.
                                r_state  <= ST_DONE;
                            end else begin
                                r_state <= ST_A_RD_MARKS;
                            end
                        end else if (32'(in_id) < NUM_IDS) begin
                            r_state <= ST_DIV_MUL;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end

                // Two passes: ID into word and bit, then word into mark entry
                // and mark bit.
                ST_DIV_MUL: begin
                    r_prod  <= MW'(((IW + MW)'(r_div_in) * (IW + MW)'(DIV_M)) >> IW);
                    r_state <= ST_DIV_BACK;
                end

                ST_DIV_BACK: begin
                    r_q     <= div_q0;
                    r_qw    <= IW'(32'(div_q0) * 32'(WORD_BITS));
                    r_state <= ST_DIV_FIX;
                end

                ST_DIV_FIX: begin
                    if (!r_div_pass) begin
                        r_word     <= WAW'(div_q);
                        r_bit      <= BW'(div_r);
                        r_div_in   <= IW'(div_q);
                        r_div_pass <= 1'b1;
                        r_state    <= ST_DIV_MUL;
                    end else begin
                        r_entry <= EW'(div_q);
                        r_mbit  <= BW'(div_r);
                        r_state <= ST_RD_USED;
                    end
                end

                ST_RD_USED: begin
                    r_state <= ST_MODIFY;
                end

                ST_MODIFY: begin
                    r_marks <= r_marks_rd;
                    case (r_mode)
                        hbia_pkg::MODE_INSERT: begin
                            r_ok      <= !present;
                            r_newword <= r_used_rd | bit_mask;
                            r_state   <= present ? ST_DONE : ST_UPDATE;
                        end
                        hbia_pkg::MODE_REMOVE: begin
                            r_ok      <= present;
                            r_newword <= r_used_rd & ~bit_mask;
                            r_state   <= present ? ST_UPDATE : ST_DONE;
                        end
                        default: begin
                            r_ok    <= present;
                            r_state <= ST_DONE;
                        end
                    endcase
                end

                // Allocate walks the levels from the top.
                ST_A_RD_MARKS: begin
                    r_state <= ST_A_MARKS;
                end

                ST_A_MARKS: begin
                    r_marks <= r_marks_rd;
                    r_mbit  <= low_bit(r_marks_rd);
                    if (r_marks_rd == '0) begin
                        r_res_id <= '0;
                        r_state  <= ST_DONE;
                    end else begin
                        r_state <= ST_A_WORD;
                    end
                end

                ST_A_WORD: begin
                    r_word  <= WAW'(32'(r_entry) * 32'(WORD_BITS) + 32'(r_mbit));
                    r_state <= ST_A_RD_USED;
                end

                ST_A_RD_USED: begin
                    r_state <= ST_A_USED;
                end

                ST_A_USED: begin
                    r_bit     <= free_bit;
                    r_newword <= r_used_rd | (WORD_BITS'(1) << free_bit);
                    if (free_bits == '0) begin
                        r_res_id <= '0;
                        r_state  <= ST_DONE;
                    end else begin
                        r_ok    <= 1'b1;
                        r_state <= ST_UPDATE;
                    end
                end

                ST_UPDATE: begin
                    r_group[r_entry] <= |new_marks;
                    if (r_mode == hbia_pkg::MODE_ALLOC) begin
                        r_res_id <= IW'(32'(r_word) * 32'(WORD_BITS) + 32'(r_bit));
                    end
                    r_state <= ST_DONE;
                end

                ST_DONE: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_ok    <= r_ok;
                        r_o_ident <= r_res_id;
                        r_state   <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_ok        = r_o_ok;
    assign o_ident_out = r_o_ident;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // A new result word only comes out of the final state.
    a_result_from_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_DONE)
    ) else $error("result word appeared outside the final state");

    // Only in-range IDs and allocations ever write back.
    a_update_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |->
            (r_inrange || r_mode == hbia_pkg::MODE_ALLOC)
    ) else $error("write-back for an out-of-range ID");

    // The word written back has the target bit in the requested sense.
    a_update_bit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |->
            (r_newword[r_bit] == (r_mode != hbia_pkg::MODE_REMOVE))
    ) else $error("written bitmap word has the wrong value at the target bit");

endmodule : hierarchical_bitmap_id_allocator

`default_nettype wire
